// ===== src/infix_integer_expression_evaluator_assert.svh =====
// Assertion macros for the infix expression evaluator.
// Include guarded; define ASSERT_OFF to compile the checks away.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define IIEE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be seen outside reset
`define IIEE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IIEE_ASSERT(label, clk, rst_n, prop, msg)
`define IIEE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/iiee_pkg.sv =====
// Shared constants and types for the infix expression evaluator.
// No dependencies; used by the arithmetic units and the top level.
package iiee_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } op_e;

  // status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== src/iiee_mul.sv =====
// Bit-serial shift-add multiplier, low word of the product, one bit a cycle.
// Depends on iiee_pkg.
module iiee_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  iiee_pkg::word_t       a_i,
  input  iiee_pkg::word_t       b_i,
  output iiee_pkg::unit_status_t status_o,
  output iiee_pkg::word_t       product_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [iiee_pkg::CNT_W-1:0] cnt_q, cnt_d;
  iiee_pkg::word_t           mcand_q, mcand_d;
  iiee_pkg::word_t           mplier_q, mplier_d;
  iiee_pkg::word_t           acc_q, acc_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = a_i;
      mplier_d = b_i;
      acc_d    = '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[iiee_pkg::WORD_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[iiee_pkg::WORD_W-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == iiee_pkg::CNT_W'(iiee_pkg::WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      acc_q    <= acc_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign product_o     = acc_q;

endmodule

// ===== src/iiee_div.sv =====
// Bit-serial restoring divider for signed words, truncating toward zero.
// One quotient bit a cycle. Depends on iiee_pkg.
module iiee_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  iiee_pkg::word_t       dividend_i,
  input  iiee_pkg::word_t       divisor_i,
  output iiee_pkg::unit_status_t status_o,
  output iiee_pkg::word_t       quotient_o
);

  localparam int W = iiee_pkg::WORD_W;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic                      neg_q, neg_d;
  logic [iiee_pkg::CNT_W-1:0] cnt_q, cnt_d;
  iiee_pkg::word_t           rem_q, rem_d;
  iiee_pkg::word_t           quo_q, quo_d;
  iiee_pkg::word_t           dsr_q, dsr_d;
  logic [W:0]                rem_sh;
  logic [W:0]                diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
      quo_d  = dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      dsr_d  = divisor_i[W-1] ? (W'(0) - divisor_i) : divisor_i;
    end else if (busy_q) begin
      // keep the trial difference only when it did not borrow
      rem_d = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
      quo_d = {quo_q[W-2:0], ~diff[W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == iiee_pkg::CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dsr_q  <= dsr_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

// ===== src/infix_integer_expression_evaluator.sv =====
// Infix integer expression evaluator, one ASCII character per request; depends on iiee_pkg,
// iiee_mul, iiee_div and the assertion header. Digits and ignored characters stay in S_IDLE.
// An operator closing a plain number or a divide by zero passes S_CLOSE and S_POST, one closing a
// multiply or divide also S_MUL or S_DIV (bit-serial units, one bit a cycle). The flagged last
// character gives its result from S_FIN, which waits for a free output; then requests resume.
// Asynchronous active-low reset clears all state; after each result the state clears too.
`include "infix_integer_expression_evaluator_assert.svh"

module infix_integer_expression_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_expr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic        div_zero_error_o
);

  localparam int W = iiee_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_MUL,
    S_DIV,
    S_POST,
    S_FIN
  } state_e;

  // what follows once the current number is folded into the term
  typedef enum logic [1:0] {
    C_SETOP,
    C_TERM_OP,
    C_TERM_END
  } cont_e;

  state_e             state_q, state_d;
  cont_e              cont_q, cont_d;
  iiee_pkg::op_e      pop_q, pop_d;
  iiee_pkg::op_e      new_op_q, new_op_d;
  logic               new_neg_q, new_neg_d;
  logic               last_q, last_d;
  iiee_pkg::word_t    sum_q, sum_d;
  iiee_pkg::word_t    term_q, term_d;
  iiee_pkg::word_t    num_q, num_d;
  logic               neg_q, neg_d;
  logic               seen_q, seen_d;
  logic               err_q, err_d;
  logic               out_valid_q, out_valid_d;
  iiee_pkg::word_t    value_q, value_d;
  logic               dz_q, dz_d;

  logic                   mul_start, div_start;
  iiee_pkg::unit_status_t mul_st, div_st;
  iiee_pkg::word_t        mul_prod, div_quo;
  logic                   accept;
  logic                   is_digit, is_op;

  iiee_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (term_q),
    .b_i       (num_q),
    .status_o  (mul_st),
    .product_o (mul_prod)
  );

  iiee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (term_q),
    .divisor_i  (num_q),
    .status_o   (div_st),
    .quotient_o (div_quo)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (char_code_i >= iiee_pkg::CHAR_ZERO) && (char_code_i <= iiee_pkg::CHAR_NINE);
  assign is_op      = (char_code_i == iiee_pkg::CHAR_PLUS) || (char_code_i == iiee_pkg::CHAR_MINUS)
                   || (char_code_i == iiee_pkg::CHAR_STAR) || (char_code_i == iiee_pkg::CHAR_SLASH);

  always_comb begin
    state_d     = state_q;
    cont_d      = cont_q;
    pop_d       = pop_q;
    new_op_d    = new_op_q;
    new_neg_d   = new_neg_q;
    last_d      = last_q;
    sum_d       = sum_q;
    term_d      = term_q;
    num_d       = num_q;
    neg_d       = neg_q;
    seen_d      = seen_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    dz_d        = dz_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = end_of_expr_i;
          cont_d = C_TERM_END;
          if (end_of_expr_i) begin
            state_d = S_CLOSE;
          end
          if (is_digit) begin
            num_d  = {num_q[W-4:0], 3'b000} + {num_q[W-2:0], 1'b0}
                   + {{(W-4){1'b0}}, char_code_i[3:0]};
            seen_d = 1'b1;
          end else if (is_op && !seen_q) begin
            if (char_code_i == iiee_pkg::CHAR_MINUS) begin
              neg_d = 1'b1;
            end
            seen_d = 1'b1;
          end else if (is_op) begin
            state_d = S_CLOSE;
            if ((char_code_i == iiee_pkg::CHAR_STAR) || (char_code_i == iiee_pkg::CHAR_SLASH)) begin
              cont_d   = C_SETOP;
              new_op_d = (char_code_i == iiee_pkg::CHAR_STAR) ? iiee_pkg::OP_MUL
                                                               : iiee_pkg::OP_DIV;
            end else begin
              cont_d    = C_TERM_OP;
              new_neg_d = (char_code_i == iiee_pkg::CHAR_MINUS);
            end
          end
        end
      end
      S_CLOSE: begin
        case (pop_q)
          iiee_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d   = S_MUL;
          end
          iiee_pkg::OP_DIV: begin
            if (num_q == '0) begin
              err_d   = 1'b1;
              term_d  = '0;
              num_d   = '0;
              state_d = S_POST;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: begin
            term_d  = num_q;
            num_d   = '0;
            state_d = S_POST;
          end
        endcase
      end
      S_MUL: begin
        if (mul_st.done) begin
          term_d  = mul_prod;
          num_d   = '0;
          state_d = S_POST;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          term_d  = div_quo;
          num_d   = '0;
          state_d = S_POST;
        end
      end
      S_POST: begin
        case (cont_q)
          C_SETOP: begin
            pop_d   = new_op_q;
            state_d = S_IDLE;
          end
          default: begin
            sum_d  = neg_q ? (sum_q - term_q) : (sum_q + term_q);
            term_d = '0;
            pop_d  = iiee_pkg::OP_NONE;
            neg_d  = (cont_q == C_TERM_OP) ? new_neg_q : 1'b0;
            state_d = S_IDLE;
          end
        endcase
        // a flagged operator still closes the term it leaves open
        if (cont_q == C_TERM_END) begin
          state_d = S_FIN;
        end else if (last_q) begin
          cont_d  = C_TERM_END;
          state_d = S_CLOSE;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = err_q ? '0 : sum_q;
          dz_d        = err_q;
          sum_d       = '0;
          term_d      = '0;
          num_d       = '0;
          pop_d       = iiee_pkg::OP_NONE;
          neg_d       = 1'b0;
          seen_d      = 1'b0;
          err_d       = 1'b0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cont_q      <= C_TERM_END;
      pop_q       <= iiee_pkg::OP_NONE;
      new_op_q    <= iiee_pkg::OP_NONE;
      new_neg_q   <= 1'b0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      term_q      <= '0;
      num_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      dz_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cont_q      <= cont_d;
      pop_q       <= pop_d;
      new_op_q    <= new_op_d;
      new_neg_q   <= new_neg_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      num_q       <= num_d;
      neg_q       <= neg_d;
      seen_q      <= seen_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      value_q     <= value_d;
      dz_q        <= dz_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign div_zero_error_o = dz_q;

  `IIEE_ASSERT(a_mul_done_in_mul, clk_i, rst_ni, mul_st.done |-> (state_q == S_MUL), "multiplier finished outside its wait state")
  `IIEE_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_st.done |-> (state_q == S_DIV), "divider finished outside its wait state")
  `IIEE_ASSERT(a_err_forces_zero, clk_i, rst_ni, (out_valid_o && div_zero_error_o) |-> (value_o == '0), "division error result not zero")
  `IIEE_ASSERT_NEVER(a_units_idle_on_request, clk_i, rst_ni, accept && (mul_st.busy || div_st.busy), "request taken while an arithmetic unit is busy")

endmodule
